FILE: rtl/core/pcsp_pkg.sv
// ----------------------------------------------------------------------------
// pcsp_pkg
// Shared constants, codes and controller/datapath interface types for the
// partition counting-sort placer.
// ----------------------------------------------------------------------------
package pcsp_pkg;

   localparam int MAX_PARTS    = 64;
   localparam int MAX_VERTICES = 65536;

   localparam int BKT_W   = $clog2(MAX_PARTS);
   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int OP_W    = 2;
   localparam int LABEL_W = 6;
   localparam int PCNT_W  = 7;
   localparam int POS_W   = 16;
   localparam int STAT_W  = 2;

   localparam int REQ_TDATA_W = 8 * ((OP_W + LABEL_W + 7) / 8);
   localparam int RSP_TDATA_W = 8 * ((POS_W + STAT_W + 7) / 8);
   localparam int RSP_PAD_W   = RSP_TDATA_W - POS_W - STAT_W;

   localparam logic [PCNT_W-1:0] PART_COUNT_RESET = PCNT_W'(64);

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_COUNT = 2'd1,
      OP_PLACE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_LABEL = 2'd1,
      ST_BEYOND    = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PLACE,
      S_SWEEP
   } state_type;

   typedef enum logic {
      WR_COUNT,
      WR_PLACE
   } wr_kind_type;

   typedef struct packed {
      logic [CNT_W-1:0] pending;
      logic [CNT_W-1:0] position;
   } entry_type;

   typedef struct packed {
      logic        clear;
      logic        total_inc;
      logic        rd_en;
      logic        rd_start;
      logic        wr_en;
      wr_kind_type wr_kind;
      logic        rsp_load;
      status_type  rsp_status;
      logic        rsp_pos_sel;
   } cmd_type;

   typedef struct packed {
      logic label_ok;
      logic full;
      logic pending_zero;
      logic sweep_last;
      logic rsp_free;
   } stat_type;

endpackage

FILE: rtl/core/pcsp_ctrl.sv
// ----------------------------------------------------------------------------
// pcsp_ctrl
// Sequencer for the placer: decodes each beat, starts bucket reads, steps the
// count sweep and tells the datapath when to write and when to load a result.
// ----------------------------------------------------------------------------
module pcsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  pcsp_pkg::op_type    req_op,
   input  pcsp_pkg::stat_type  stat,
   output pcsp_pkg::cmd_type   cmd
);
   import pcsp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd            = '0;
      cmd.wr_kind    = WR_COUNT;
      cmd.rsp_status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = stat.rsp_free;
            if (req_tvalid && stat.rsp_free) begin
               unique case (req_op)
                  OP_CLEAR: begin
                     cmd.clear    = 1'b1;
                     cmd.rsp_load = 1'b1;
                  end
                  OP_COUNT: begin
                     cmd.rsp_load = 1'b1;
                     if (!stat.label_ok) begin
                        cmd.rsp_status = ST_BAD_LABEL;
                     end else if (stat.full) begin
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        cmd.total_inc = 1'b1;
                        cmd.rd_en     = 1'b1;
                        cmd.rd_start  = 1'b1;
                        state_in      = S_SWEEP;
                     end
                  end
                  OP_PLACE: begin
                     if (!stat.label_ok) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_BAD_LABEL;
                     end else begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_start = 1'b1;
                        state_in     = S_PLACE;
                     end
                  end
                  OP_NONE: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_PLACE: begin
            // The bucket word is in the read register; wait for room at the output.
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               if (stat.pending_zero) begin
                  cmd.rsp_status = ST_BEYOND;
               end else begin
                  cmd.wr_en       = 1'b1;
                  cmd.wr_kind     = WR_PLACE;
                  cmd.rsp_pos_sel = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_SWEEP: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_kind = WR_COUNT;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/pcsp_datapath.sv
// ----------------------------------------------------------------------------
// pcsp_datapath
// Bucket RAM with per-bucket valid bits, the read/modify/write path, the
// counted total, the partition-count register and the result register.
// ----------------------------------------------------------------------------
module pcsp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pcsp_pkg::LABEL_W-1:0]        req_label,
   input  logic                                csr_valid,
   input  logic [pcsp_pkg::PCNT_W-1:0]         csr_wdata,
   input  pcsp_pkg::cmd_type                   cmd,
   output pcsp_pkg::stat_type                  stat,
   input  logic                                rsp_tready,
   output logic                                rsp_valid,
   output logic [pcsp_pkg::POS_W-1:0]          rsp_pos,
   output pcsp_pkg::status_type                rsp_status
);
   import pcsp_pkg::*;

   logic [PCNT_W-1:0]    part_count_ff;
   logic [CNT_W-1:0]     total_ff;
   logic [MAX_PARTS-1:0] valid_ff;
   entry_type            bucket_ff [MAX_PARTS];
   entry_type            rd_data_ff;
   logic                 rd_valid_ff;
   logic [BKT_W-1:0]     addr_ff;
   logic [BKT_W-1:0]     lab_ff;
   logic [BKT_W-1:0]     rd_addr;
   entry_type            entry;
   entry_type            wr_data;
   logic                 rsp_valid_ff;
   logic [POS_W-1:0]     rsp_pos_ff;
   status_type           rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         part_count_ff <= PART_COUNT_RESET;
      end else if (csr_valid) begin
         part_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         total_ff <= '0;
      end else if (cmd.total_inc) begin
         total_ff <= total_ff + CNT_W'(1);
      end
   end

   // A bucket never written since the last clear reads as all zero.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[addr_ff] <= 1'b1;
      end
   end

   assign rd_addr = cmd.rd_start ? BKT_W'(req_label) : addr_ff + BKT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         addr_ff     <= rd_addr;
         rd_data_ff  <= bucket_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.rd_start) begin
         lab_ff <= BKT_W'(req_label);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         bucket_ff[addr_ff] <= wr_data;
      end
   end

   assign entry = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      wr_data = entry;
      unique case (cmd.wr_kind)
         WR_PLACE: begin
            wr_data.pending  = entry.pending - CNT_W'(1);
            wr_data.position = entry.position + CNT_W'(1);
         end
         WR_COUNT: begin
            if (addr_ff == lab_ff) begin
               wr_data.pending = entry.pending + CNT_W'(1);
            end else begin
               wr_data.position = entry.position + CNT_W'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_pos_ff    <= cmd.rsp_pos_sel ? entry.position[POS_W-1:0] : '0;
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   assign stat.label_ok     = (PCNT_W'(req_label) < part_count_ff) &&
                              (32'(req_label) < MAX_PARTS);
   assign stat.full         = total_ff >= CNT_W'(MAX_VERTICES);
   assign stat.pending_zero = entry.pending == '0;
   assign stat.sweep_last   = addr_ff == BKT_W'(MAX_PARTS - 1);
   assign stat.rsp_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pos    = rsp_pos_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: rtl/core/partition_counting_sort_placer.sv
// ----------------------------------------------------------------------------
// partition_counting_sort_placer
// Stable counting-sort bucket placer: counts vertices per partition label,
// then hands out each vertex's new index from its bucket's next position.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Ports                      Beat contents (low bit up)
// -------  ---------  -------------------------  -------------------------------
// req      in         req_tvalid/tready/tdata    operation[1:0], label[7:2]
// rsp      out        rsp_tvalid/tready/tdata    new_position[15:0], status[17:16]
// csr      in         csr_valid/ready/wdata      part_count[6:0]
//
// A clear, an unused operation code, a beat with a bad label and a count
// refused as full are answered straight from the idle state. A place first
// reads the bucket word from the bucket RAM, then, once the result register
// has room, writes it back with its position advanced unless none is pending.
// A count walks the bucket RAM from its own bucket to the top one, one read and
// one write per cycle, bumping every higher bucket's position.
// Reset is synchronous; it drops all bucket valid bits at once, zeroes the
// counted total and sets part_count to 64. No result is pending after reset.
// A request beat is taken only while the controller is idle and the result
// register is empty or being emptied; a stalled result holds its beat.
//
// The bucket state lives in a MAX_PARTS-deep RAM of {pending, position} words.
// Each bucket has a valid bit; a clear drops them all at once and a bucket that
// has not been written since reads as zero.
//
module partition_counting_sort_placer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pcsp_pkg::REQ_TDATA_W-1:0]    req_tdata,  // operation, label
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pcsp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // new_position, status
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcsp_pkg::PCNT_W-1:0]         csr_wdata
);
   import pcsp_pkg::*;

   cmd_type              cmd;
   stat_type             stat;
   op_type               req_op;
   logic [LABEL_W-1:0]   req_label;
   logic [POS_W-1:0]     rsp_pos;
   status_type           rsp_status;

   assign req_op    = op_type'(req_tdata[OP_W-1:0]);
   assign req_label = req_tdata[OP_W +: LABEL_W];

   // The partition count register takes a write in any cycle.
   assign csr_ready = 1'b1;

   pcsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .stat       (stat),
      .cmd        (cmd)
   );

   pcsp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_label  (req_label),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_pos    (rsp_pos),
      .rsp_status (rsp_status)
   );

   // The upper bits of the result beat are zero fill.
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_status, rsp_pos};

endmodule

FILE: rtl/core/pcsp_checker.sv
// ----------------------------------------------------------------------------
// pcsp_checker
// Port-level checks for the placer, bound to the top level.
// ----------------------------------------------------------------------------
module pcsp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [pcsp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [pcsp_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import pcsp_pkg::*;

   logic       req_fire;
   status_type rsp_st;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_st   = status_type'(rsp_tdata[POS_W +: STAT_W]);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // A result with an error status carries a zero position.
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_st != ST_OK |-> rsp_tdata[POS_W-1:0] == '0)
      else $error("error result with nonzero position");

   // A clear answers in the next cycle with an ok status.
   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tdata[OP_W-1:0] == OP_CLEAR |=> rsp_tvalid && rsp_st == ST_OK)
      else $error("clear did not answer ok at once");

   // An accepted count starts the bucket sweep, so no beat is taken right after.
   a_count_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tdata[OP_W-1:0] == OP_COUNT ##1 rsp_st == ST_OK |-> !req_tready)
      else $error("request taken during count sweep");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind partition_counting_sort_placer pcsp_checker u_pcsp_checker (.*);

FILE: tb/sv/tb_partition_counting_sort_placer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_partition_counting_sort_placer
// Self-checking bench for the counting-sort bucket placer. A bucket tracker
// class mirrors the per-bucket next positions, pending counts and counted
// total, works out the position and status of every accepted request beat,
// and compares each response beat against the oldest prediction. Stimulus is
// a short directed run, then count-then-place batches mixed with noise under
// several part_count settings.
// ----------------------------------------------------------------------------
module tb_partition_counting_sort_placer;
   import pcsp_pkg::*;

   // Generous ceiling: about 800 beats, with stalls and drains, stay well below it.
   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam int          IDLE_PCT    = 21;
   localparam int          PHASES      = 8;
   localparam int          PHASE_BEATS = 90;

   // Predictor and response checker. State mirrors the bucket RAM of the block.
   class bucket_tracker_type;
      typedef struct {
         logic [POS_W-1:0] position;
         status_type       status;
      } placement_type;

      logic [CNT_W-1:0]  next_pos [MAX_PARTS];
      logic [CNT_W-1:0]  pending  [MAX_PARTS];
      logic [CNT_W-1:0]  total_counted;
      logic [PCNT_W-1:0] part_count;
      placement_type     expected_q [$];
      int unsigned       mismatches;

      function new();
         clear_buckets();
         part_count = PART_COUNT_RESET;
         mismatches = 0;
      endfunction

      function void clear_buckets();
         foreach (next_pos[b]) begin
            next_pos[b] = '0;
            pending[b]  = '0;
         end
         total_counted = '0;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      // Called for every request beat accepted by the block.
      function void note_request(op_type op, logic [LABEL_W-1:0] label);
         placement_type exp_item;
         bit            lab_ok;
         lab_ok = (label < part_count) && (label < MAX_PARTS);
         exp_item.position = '0;
         exp_item.status   = ST_OK;
         case (op)
            OP_CLEAR: begin
               clear_buckets();
            end
            OP_COUNT: begin
               if (!lab_ok) begin
                  exp_item.status = ST_BAD_LABEL;
               end else if (total_counted >= MAX_VERTICES) begin
                  exp_item.status = ST_FULL;
               end else begin
                  // Every higher bucket moves up by one, which keeps each
                  // bucket's next position at the exclusive prefix sum.
                  pending[label] = pending[label] + 1'b1;
                  for (int b = int'(label) + 1; b < MAX_PARTS; b++)
                     next_pos[b] = next_pos[b] + 1'b1;
                  total_counted = total_counted + 1'b1;
               end
            end
            OP_PLACE: begin
               if (!lab_ok) begin
                  exp_item.status = ST_BAD_LABEL;
               end else if (pending[label] == '0) begin
                  exp_item.status = ST_BEYOND;
               end else begin
                  exp_item.position = next_pos[label][POS_W-1:0];
                  next_pos[label]   = next_pos[label] + 1'b1;
                  pending[label]    = pending[label] - 1'b1;
               end
            end
            default: begin
               // The unused operation code leaves the buckets alone.
            end
         endcase
         expected_q = {expected_q, exp_item};
      endfunction

      // Called for every response beat accepted from the block.
      function void check_response(logic [RSP_TDATA_W-1:0] tdata);
         placement_type    exp_item;
         logic [POS_W-1:0] got_pos;
         status_type       got_st;
         got_pos = tdata[POS_W-1:0];
         got_st  = status_type'(tdata[POS_W +: STAT_W]);
         if (expected_q.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected response beat: position %0d status %s",
                        got_pos, got_st.name());
            mismatches++;
            return;
         end
         exp_item = expected_q.pop_front();
         if (got_pos !== exp_item.position || got_st !== exp_item.status) begin
            if (mismatches < 10)
               $display("response mismatch: expected position %0d status %s, got %0d %s",
                        exp_item.position, exp_item.status.name(), got_pos, got_st.name());
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // operation[1:0], label[7:2]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // new_position[15:0], status[17:16]
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [PCNT_W-1:0]      csr_wdata = '0;   // part_count[6:0]

   bucket_tracker_type     tracker = new();
   bit                     idle_on = 1'b1;
   int unsigned            cycle_count = 0;
   int unsigned            sent_count = 0;

   partition_counting_sort_placer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The watchdog stops a hung run; a correct run never gets near the limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_partition_counting_sort_placer: FAIL");
         $finish;
      end
   end

   // The response side stalls at random while idling is enabled. Inputs move
   // on the falling edge so the block samples settled values at the rising one.
   always @(negedge clock) begin
      rsp_tready = !idle_on || ($urandom_range(99) >= IDLE_PCT);
   end

   // Response beats are taken at the rising edge where valid and ready meet.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_response(rsp_tdata);
   end

   // Presents one request beat and holds it until the block takes it. Valid
   // stays high between back-to-back beats; it only drops for an idle gap.
   task automatic send_beat(op_type op, logic [LABEL_W-1:0] label);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = REQ_TDATA_W'({label, op});
      do @(posedge clock); while (!req_tready);
      tracker.note_request(op, label);
      sent_count++;
   endtask

   task automatic send_noise();
      send_beat(op_type'($urandom_range(3)), LABEL_W'($urandom_range(63)));
   endtask

   // Lowers valid and waits until every prediction has been matched, then
   // lets the longest count walk finish before anything else happens.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (MAX_PARTS + 8) @(posedge clock);
   endtask

   // part_count is only changed once the block has gone quiet.
   task automatic write_part_count(logic [PCNT_W-1:0] value);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      tracker.part_count = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One well-formed sort: optionally clear, count a handful of labels, then
   // place them in a shuffled order. A few beats of noise, a dropped place
   // and an extra place keep the error paths busy.
   task automatic run_sort_batch();
      logic [LABEL_W-1:0] labels [$];
      logic [LABEL_W-1:0] swap;
      int                 lim;
      int                 n;
      int                 j;
      lim = (tracker.part_count > MAX_PARTS) ? MAX_PARTS : int'(tracker.part_count);
      if (lim == 0) begin
         repeat (4) send_noise();
         return;
      end
      if ($urandom_range(99) < 80)
         send_beat(OP_CLEAR, LABEL_W'($urandom_range(63)));
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         labels = {labels, LABEL_W'($urandom_range(lim - 1))};
         send_beat(OP_COUNT, labels[i]);
         if ($urandom_range(99) < 8)
            send_noise();
      end
      for (int i = n - 1; i > 0; i--) begin
         j         = $urandom_range(i);
         swap      = labels[i];
         labels[i] = labels[j];
         labels[j] = swap;
      end
      if ($urandom_range(99) < 10)
         void'(labels.pop_back());
      foreach (labels[i]) begin
         send_beat(OP_PLACE, labels[i]);
         if ($urandom_range(99) < 8)
            send_noise();
      end
      if ($urandom_range(99) < 15)
         send_beat(OP_PLACE, LABEL_W'($urandom_range(lim - 1)));
   endtask

   initial begin
      logic [PCNT_W-1:0] settings [PHASES];
      int unsigned       phase_start;

      settings = '{7'd64, 7'd1, PCNT_W'($urandom_range(2, 63)), 7'd0, 7'd127,
                   PCNT_W'($urandom_range(2, 63)), 7'd64, 7'd65};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed run at the reset part_count of 64: a place into an empty
      // bucket, counts on both end buckets, stable places, a place beyond
      // the count, the unused operation code and a clear.
      send_beat(OP_PLACE, 6'd0);
      send_beat(OP_COUNT, 6'd63);
      send_beat(OP_COUNT, 6'd0);
      send_beat(OP_COUNT, 6'd0);
      send_beat(OP_COUNT, 6'd31);
      send_beat(OP_COUNT, 6'd63);
      send_beat(OP_PLACE, 6'd63);
      send_beat(OP_PLACE, 6'd0);
      send_beat(OP_PLACE, 6'd0);
      send_beat(OP_PLACE, 6'd31);
      send_beat(OP_PLACE, 6'd63);
      send_beat(OP_PLACE, 6'd63);
      send_beat(OP_NONE, 6'd63);
      send_beat(OP_NONE, 6'd0);
      send_beat(OP_CLEAR, 6'd0);
      send_beat(OP_PLACE, 6'd0);

      // With a single partition every label above zero is out of range.
      write_part_count(7'd1);
      send_beat(OP_COUNT, 6'd1);
      send_beat(OP_PLACE, 6'd63);
      send_beat(OP_COUNT, 6'd0);
      send_beat(OP_PLACE, 6'd0);
      send_beat(OP_PLACE, 6'd0);

      // Random batches, one part_count setting per phase. The seventh phase
      // runs with no idling on either side.
      for (int p = 0; p < PHASES; p++) begin
         write_part_count(settings[p]);
         idle_on     = (p != 6);
         phase_start = sent_count;
         while (sent_count - phase_start < PHASE_BEATS) begin
            if ($urandom_range(99) < 20) begin
               repeat ($urandom_range(1, 6)) send_noise();
            end else begin
               run_sort_batch();
            end
         end
      end

      idle_on = 1'b1;
      drain();

      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("tb_partition_counting_sort_placer: PASS");
      end else begin
         $display("tb_partition_counting_sort_placer: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/pcsp_pkg.sv
rtl/core/pcsp_ctrl.sv
rtl/core/pcsp_datapath.sv
rtl/core/partition_counting_sort_placer.sv
rtl/core/pcsp_checker.sv
tb/sv/tb_partition_counting_sort_placer.sv
